/* src/bresenham_line_raster_assert.svh */
// ----------------------------------------------------------------------------
// bresenham_line_raster_assert
// assertion macros shared by the line rasterizer
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTER_ASSERT_SVH
`define BRESENHAM_LINE_RASTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bresenham_line_raster: same-cycle check failed");

// next-cycle implication, checked outside reset
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bresenham_line_raster: next-cycle check failed");

`endif

/* src/blr_pkg.sv */
// ----------------------------------------------------------------------------
// blr_pkg
// types and constants for the midpoint line rasterizer
// ----------------------------------------------------------------------------
package blr_pkg;

   // image size registers
   localparam int CFG_BITS = 12;
   localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   // register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // item modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   localparam int COLOR_BITS = 24;

   // octant of the original line, walked in first-octant coordinates
   typedef enum logic [1:0] {
      OCT_1 = 2'd0,
      OCT_2 = 2'd1,
      OCT_7 = 2'd2,
      OCT_8 = 2'd3
   } octant_type;

endpackage

/* src/bresenham_line_raster.sv */
// ----------------------------------------------------------------------------
// bresenham_line_raster
// Midpoint line rasterizer. A start item sets up a line from two endpoints and
// a color and returns its first pixel; each step item returns the next pixel
// (or an invalid result when no line is in progress). Every item gives exactly
// one result, in the cycle after it is accepted, and a new item is taken every
// cycle: the whole step (error update, octant remap, bounds test) sits between
// the input handshake and the result register, and req_ready stays high while
// the result register is empty or being drained.
// ----------------------------------------------------------------------------
`include "bresenham_line_raster_assert.svh"

module bresenham_line_raster #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_write_en,
   input  logic                                  csr_index,
   input  logic [blr_pkg::CFG_BITS-1:0]          csr_write_data,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [COORD_BITS-1:0]          req_x_start,
   input  logic signed [COORD_BITS-1:0]          req_y_start,
   input  logic signed [COORD_BITS-1:0]          req_x_end,
   input  logic signed [COORD_BITS-1:0]          req_y_end,
   input  logic [blr_pkg::COLOR_BITS-1:0]        req_color_in,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_pixel_valid,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [blr_pkg::COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                                  rsp_inside_image,
   output logic                                  rsp_last_pixel
);

   localparam int SPAN_BITS = COORD_BITS + 1;
   localparam int ERR_BITS  = COORD_BITS + 4;
   localparam int BND_BITS  =
      ((COORD_BITS > blr_pkg::CFG_BITS) ? COORD_BITS : blr_pkg::CFG_BITS) + 1;

   // configuration
   logic [blr_pkg::CFG_BITS-1:0] width_ff, width_in;
   logic [blr_pkg::CFG_BITS-1:0] height_ff, height_in;

   // line state
   logic                         active_ff, active_in;
   logic signed [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   blr_pkg::octant_type          octant_ff, octant_in;
   logic signed [SPAN_BITS-1:0]  walk_x_ff, walk_x_in;
   logic signed [SPAN_BITS-1:0]  walk_y_ff, walk_y_in;
   logic signed [SPAN_BITS-1:0]  major_ff, major_in;
   logic signed [SPAN_BITS-1:0]  minor_ff, minor_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic [blr_pkg::COLOR_BITS-1:0] color_ff, color_in;

   // result register
   logic                         out_valid_ff, out_valid_in;
   logic                         out_pix_valid_ff, out_pix_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic signed [COORD_BITS-1:0] out_y_ff, out_y_in;
   logic [blr_pkg::COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                         out_inside_ff, out_inside_in;
   logic                         out_last_ff, out_last_in;

   logic accept;
   logic is_start;

   // start setup
   logic                         swap;
   logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
   logic signed [SPAN_BITS-1:0]  dx, dy, ady;
   logic                         steep;
   blr_pkg::octant_type          st_octant;
   logic signed [SPAN_BITS-1:0]  st_major, st_minor;
   logic signed [ERR_BITS-1:0]   st_error;

   // step
   logic                         east;
   logic signed [ERR_BITS-1:0]   step_error;
   logic signed [SPAN_BITS-1:0]  step_wx, step_wy;
   logic                         step_last;
   logic signed [COORD_BITS-1:0] off_x, off_y;
   logic signed [COORD_BITS-1:0] step_px, step_py;

   // emitted pixel
   logic signed [COORD_BITS-1:0] pix_x, pix_y;
   logic                         in_bounds;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_start  = (req_mode == blr_pkg::MODE_START);

   // ---------------- start setup: order endpoints, pick octant
   always_comb begin
      swap = (req_x_end < req_x_start);
      xa   = swap ? req_x_end   : req_x_start;
      ya   = swap ? req_y_end   : req_y_start;
      xb   = swap ? req_x_start : req_x_end;
      yb   = swap ? req_y_start : req_y_end;
      dx   = SPAN_BITS'(xb) - SPAN_BITS'(xa);
      dy   = SPAN_BITS'(yb) - SPAN_BITS'(ya);
      ady  = dy[SPAN_BITS-1] ? -dy : dy;
      steep = (ady > dx);
      if (steep) begin
         st_octant = (!dy[SPAN_BITS-1] && (dy != '0)) ? blr_pkg::OCT_2 : blr_pkg::OCT_7;
         st_major  = ady;
         st_minor  = dx;
      end else begin
         st_octant = dy[SPAN_BITS-1] ? blr_pkg::OCT_8 : blr_pkg::OCT_1;
         st_major  = dx;
         st_minor  = ady;
      end
      st_error = (ERR_BITS'(st_minor) <<< 1) - ERR_BITS'(st_major);
   end

   // ---------------- step: midpoint decision and octant remap
   always_comb begin
      east = error_ff[ERR_BITS-1] || (error_ff == '0);
      if (east) begin
         step_error = error_ff + (ERR_BITS'(minor_ff) <<< 1);
         step_wy    = walk_y_ff;
      end else begin
         step_error = error_ff + ((ERR_BITS'(minor_ff) - ERR_BITS'(major_ff)) <<< 1);
         step_wy    = walk_y_ff + SPAN_BITS'(1);
      end
      step_wx   = walk_x_ff + SPAN_BITS'(1);
      step_last = (step_wx >= major_ff);

      case (octant_ff)
         blr_pkg::OCT_2: begin
            off_x = step_wy[COORD_BITS-1:0];
            off_y = step_wx[COORD_BITS-1:0];
         end
         blr_pkg::OCT_7: begin
            off_x = step_wy[COORD_BITS-1:0];
            off_y = -step_wx[COORD_BITS-1:0];
         end
         blr_pkg::OCT_8: begin
            off_x = step_wx[COORD_BITS-1:0];
            off_y = -step_wy[COORD_BITS-1:0];
         end
         default: begin
            off_x = step_wx[COORD_BITS-1:0];
            off_y = step_wy[COORD_BITS-1:0];
         end
      endcase
      step_px = origin_x_ff + off_x;
      step_py = origin_y_ff + off_y;
   end

   // ---------------- pixel select and bounds test
   always_comb begin
      pix_x = is_start ? xa : step_px;
      pix_y = is_start ? ya : step_py;
      in_bounds = !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1] &&
                  (BND_BITS'($unsigned(pix_x)) < BND_BITS'(width_ff)) &&
                  (BND_BITS'($unsigned(pix_y)) < BND_BITS'(height_ff));
   end

   // ---------------- next state
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      active_in   = active_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      octant_in   = octant_ff;
      walk_x_in   = walk_x_ff;
      walk_y_in   = walk_y_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      error_in    = error_ff;
      color_in    = color_ff;

      out_valid_in     = out_valid_ff && !rsp_ready;
      out_pix_valid_in = out_pix_valid_ff;
      out_x_in         = out_x_ff;
      out_y_in         = out_y_ff;
      out_color_in     = out_color_ff;
      out_inside_in    = out_inside_ff;
      out_last_in      = out_last_ff;

      if (csr_write_en) begin
         case (csr_index)
            blr_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            blr_pkg::CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end

      if (accept) begin
         out_valid_in = 1'b1;
         if (is_start) begin
            active_in   = (st_major != '0);
            origin_x_in = xa;
            origin_y_in = ya;
            octant_in   = st_octant;
            walk_x_in   = '0;
            walk_y_in   = '0;
            major_in    = st_major;
            minor_in    = st_minor;
            error_in    = st_error;
            color_in    = req_color_in;

            out_pix_valid_in = 1'b1;
            out_x_in         = pix_x;
            out_y_in         = pix_y;
            out_color_in     = req_color_in;
            out_inside_in    = in_bounds;
            out_last_in      = (st_major == '0);
         end else if (active_ff) begin
            active_in = !step_last;
            walk_x_in = step_wx;
            walk_y_in = step_wy;
            error_in  = step_error;

            out_pix_valid_in = 1'b1;
            out_x_in         = pix_x;
            out_y_in         = pix_y;
            out_color_in     = color_ff;
            out_inside_in    = in_bounds;
            out_last_in      = step_last;
         end else begin
            // step with no line in progress
            out_pix_valid_in = 1'b0;
            out_x_in         = '0;
            out_y_in         = '0;
            out_color_in     = '0;
            out_inside_in    = 1'b0;
            out_last_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= blr_pkg::IMAGE_WIDTH_RESET;
         height_ff    <= blr_pkg::IMAGE_HEIGHT_RESET;
         active_ff    <= 1'b0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         octant_ff    <= blr_pkg::OCT_1;
         walk_x_ff    <= '0;
         walk_y_ff    <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
         error_ff     <= '0;
         color_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         active_ff    <= active_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         octant_ff    <= octant_in;
         walk_x_ff    <= walk_x_in;
         walk_y_ff    <= walk_y_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         error_ff     <= error_in;
         color_ff     <= color_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_valid_ff <= out_pix_valid_in;
      out_x_ff         <= out_x_in;
      out_y_ff         <= out_y_in;
      out_color_ff     <= out_color_in;
      out_inside_ff    <= out_inside_in;
      out_last_ff      <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_valid  = out_pix_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_pixel_color  = out_color_ff;
   assign rsp_inside_image = out_inside_ff;
   assign rsp_last_pixel   = out_last_ff;

   // ---------------- assertions
   // an active line has not yet reached its last pixel
   `BLR_ASSERT_NOW(a_walk_below_major, clock, reset, active_ff, walk_x_ff < major_ff)
   // an item whose result is the last pixel ends the line
   `BLR_ASSERT_NEXT(a_last_ends_line, clock, reset, accept && out_last_in, !active_ff)
   // invalid results carry no flags
   `BLR_ASSERT_NOW(a_invalid_quiet, clock, reset, out_valid_ff && !out_pix_valid_ff,
                   !out_inside_ff && !out_last_ff)
   // a pixel inside the image has nonnegative coordinates
   `BLR_ASSERT_NOW(a_inside_nonneg, clock, reset, out_valid_ff && out_inside_ff,
                   !out_x_ff[COORD_BITS-1] && !out_y_ff[COORD_BITS-1])

endmodule

/* tb/tb_bresenham_line_raster.sv */
// ----------------------------------------------------------------------------
// tb_bresenham_line_raster
// Self-checking bench for the midpoint line rasterizer. Lines in all four
// octants are started and walked with random content, stray steps and
// restarts mixed in, under several image sizes. A line walker in the bench
// predicts every pixel, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_bresenham_line_raster;

   localparam int COORD_BITS  = 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 215;

   typedef struct packed {
      logic                           pixel_valid;
      logic [COORD_BITS-1:0]          pixel_x;
      logic [COORD_BITS-1:0]          pixel_y;
      logic [blr_pkg::COLOR_BITS-1:0] pixel_color;
      logic                           inside_image;
      logic                           last_pixel;
   } pixel_type;

   class line_scoreboard;
      pixel_type                      expected_q[$];
      int unsigned                    mismatches;
      logic [blr_pkg::CFG_BITS-1:0]   image_width;
      logic [blr_pkg::CFG_BITS-1:0]   image_height;
      bit                             line_active;
      int                             origin_x;
      int                             origin_y;
      blr_pkg::octant_type            octant;
      int                             walk_x;
      int                             walk_y;
      int                             span_major;
      int                             span_minor;
      int                             error_term;
      logic [blr_pkg::COLOR_BITS-1:0] line_color;

      function new();
         mismatches   = 0;
         image_width  = blr_pkg::IMAGE_WIDTH_RESET;
         image_height = blr_pkg::IMAGE_HEIGHT_RESET;
         line_active  = 1'b0;
         origin_x     = 0;
         origin_y     = 0;
         octant       = blr_pkg::OCT_1;
         walk_x       = 0;
         walk_y       = 0;
         span_major   = 0;
         span_minor   = 0;
         error_term   = 0;
         line_color   = '0;
      endfunction

      function void set_image_size(logic idx, logic [blr_pkg::CFG_BITS-1:0] value);
         if (idx == blr_pkg::CSR_IMAGE_WIDTH) begin
            image_width = value;
         end else begin
            image_height = value;
         end
      endfunction

      // map the walker position back to the original octant
      function pixel_type place_pixel(bit last);
         pixel_type p;
         int        px;
         int        py;
         case (octant)
            blr_pkg::OCT_2: begin
               px = walk_y;
               py = walk_x;
            end
            blr_pkg::OCT_7: begin
               px = walk_y;
               py = -walk_x;
            end
            blr_pkg::OCT_8: begin
               px = walk_x;
               py = -walk_y;
            end
            default: begin
               px = walk_x;
               py = walk_y;
            end
         endcase
         px = px + origin_x;
         py = py + origin_y;
         p.pixel_valid  = 1'b1;
         p.pixel_x      = px[COORD_BITS-1:0];
         p.pixel_y      = py[COORD_BITS-1:0];
         p.pixel_color  = line_color;
         p.inside_image = (px >= 0) && (py >= 0) && (px < int'(image_width)) &&
                          (py < int'(image_height));
         p.last_pixel   = last;
         return p;
      endfunction

      function void note_item(logic mode, logic signed [COORD_BITS-1:0] xs,
                              logic signed [COORD_BITS-1:0] ys,
                              logic signed [COORD_BITS-1:0] xe,
                              logic signed [COORD_BITS-1:0] ye,
                              logic [blr_pkg::COLOR_BITS-1:0] color);
         int xa;
         int ya;
         int xb;
         int yb;
         int dx;
         int dy;
         int ady;
         bit last;
         if (mode == blr_pkg::MODE_START) begin
            xa = int'(xs);
            ya = int'(ys);
            xb = int'(xe);
            yb = int'(ye);
            if (xb < xa) begin
               xa = int'(xe);
               ya = int'(ye);
               xb = int'(xs);
               yb = int'(ys);
            end
            dx  = xb - xa;
            dy  = yb - ya;
            ady = (dy < 0) ? -dy : dy;
            if (ady > dx) begin
               octant     = (dy > 0) ? blr_pkg::OCT_2 : blr_pkg::OCT_7;
               span_major = ady;
               span_minor = dx;
            end else begin
               octant     = (dy < 0) ? blr_pkg::OCT_8 : blr_pkg::OCT_1;
               span_major = dx;
               span_minor = ady;
            end
            origin_x    = xa;
            origin_y    = ya;
            walk_x      = 0;
            walk_y      = 0;
            error_term  = 2 * span_minor - span_major;
            line_color  = color;
            last        = (span_major == 0);
            line_active = !last;
            expected_q.push_back(place_pixel(last));
         end else if (!line_active) begin
            expected_q.push_back('0);
         end else begin
            if (error_term <= 0) begin
               error_term = error_term + 2 * span_minor;
            end else begin
               error_term = error_term + 2 * (span_minor - span_major);
               walk_y++;
            end
            walk_x++;
            last = (walk_x >= span_major);
            if (last) begin
               line_active = 1'b0;
            end
            expected_q.push_back(place_pixel(last));
         end
      endfunction

      task report_mismatch(string field, longint unsigned got, longint unsigned want);
         $display("mismatch on %s: got %0h expected %0h", field, got, want);
         mismatches++;
      endtask

      task check_result(pixel_type got);
         pixel_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", 64'(got), 64'd0);
         end else begin
            want = expected_q.pop_front();
            if (got.pixel_valid !== want.pixel_valid)
               report_mismatch("pixel_valid", 64'(got.pixel_valid), 64'(want.pixel_valid));
            if (got.pixel_x !== want.pixel_x)
               report_mismatch("pixel_x", 64'(got.pixel_x), 64'(want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
               report_mismatch("pixel_y", 64'(got.pixel_y), 64'(want.pixel_y));
            if (got.pixel_color !== want.pixel_color)
               report_mismatch("pixel_color", 64'(got.pixel_color), 64'(want.pixel_color));
            if (got.inside_image !== want.inside_image)
               report_mismatch("inside_image", 64'(got.inside_image),
                               64'(want.inside_image));
            if (got.last_pixel !== want.last_pixel)
               report_mismatch("last_pixel", 64'(got.last_pixel), 64'(want.last_pixel));
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic                           csr_index = blr_pkg::CSR_IMAGE_WIDTH;
   logic [blr_pkg::CFG_BITS-1:0]   csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_mode = blr_pkg::MODE_START;
   logic signed [COORD_BITS-1:0]   req_x_start = '0;
   logic signed [COORD_BITS-1:0]   req_y_start = '0;
   logic signed [COORD_BITS-1:0]   req_x_end = '0;
   logic signed [COORD_BITS-1:0]   req_y_end = '0;
   logic [blr_pkg::COLOR_BITS-1:0] req_color_in = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_pixel_valid;
   logic signed [COORD_BITS-1:0]   rsp_pixel_x;
   logic signed [COORD_BITS-1:0]   rsp_pixel_y;
   logic [blr_pkg::COLOR_BITS-1:0] rsp_pixel_color;
   logic                           rsp_inside_image;
   logic                           rsp_last_pixel;

   line_scoreboard sb = new();
   int             cycle_count = 0;
   int             sent_count = 0;
   int             cur_width = int'(blr_pkg::IMAGE_WIDTH_RESET);
   int             cur_height = int'(blr_pkg::IMAGE_HEIGHT_RESET);
   bit             no_idle = 1'b0;
   bit             hold_request = 1'b0;

   bresenham_line_raster #(
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_color_in     (req_color_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_valid  (rsp_pixel_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_inside_image (rsp_inside_image),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // sample handshakes on the edge, before any of this edge's updates land
   always @(posedge clock) begin : monitor
      pixel_type got;
      if (!reset) begin
         if (csr_write_en) begin
            sb.set_image_size(csr_index, csr_write_data);
         end
         if (req_valid && req_ready) begin
            sb.note_item(req_mode, req_x_start, req_y_start, req_x_end, req_y_end,
                         req_color_in);
         end
         if (rsp_valid && rsp_ready) begin
            got.pixel_valid  = rsp_pixel_valid;
            got.pixel_x      = rsp_pixel_x;
            got.pixel_y      = rsp_pixel_y;
            got.pixel_color  = rsp_pixel_color;
            got.inside_image = rsp_inside_image;
            got.last_pixel   = rsp_last_pixel;
            sb.check_result(got);
         end
      end
   end

   // result side back-pressure, with a long hold-off when the sender asks
   initial begin
      int hold;
      int r;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = $urandom_range(40, 100);
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
            end
         end
      end
   end

   function automatic int clamp_coord(int v);
      if (v < -2048) return -2048;
      if (v > 2047) return 2047;
      return v;
   endfunction

   // near the origin, near the image edge, anywhere, or anywhere nonnegative
   function automatic int pick_coord(int edge_at);
      case ($urandom_range(0, 3))
         0: return int'($urandom_range(0, 4095)) - 2048;
         1: return int'($urandom_range(0, 16)) - 8;
         2: return clamp_coord(edge_at + int'($urandom_range(0, 8)) - 4);
         default: return int'($urandom_range(0, 2047));
      endcase
   endfunction

   // called at a clock edge; returns at the edge where the item is taken
   task automatic send_item(logic mode, int xs, int ys, int xe, int ye,
                            logic [blr_pkg::COLOR_BITS-1:0] color);
      int gap;
      int r;
      if ($urandom_range(0, 119) == 0) begin
         no_idle = !no_idle;
      end
      gap = 0;
      if (!no_idle) begin
         r = $urandom_range(0, 99);
         if (r >= 90) begin
            gap = $urandom_range(4, 24);
         end else if (r >= 60) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_x_start  <= xs[COORD_BITS-1:0];
      req_y_start  <= ys[COORD_BITS-1:0];
      req_x_end    <= xe[COORD_BITS-1:0];
      req_y_end    <= ye[COORD_BITS-1:0];
      req_color_in <= color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // step items carry junk in the unused fields
   task automatic send_step();
      send_item(blr_pkg::MODE_STEP, int'($urandom_range(0, 4095)) - 2048,
                int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                int'($urandom_range(0, 4095)) - 2048, 24'($urandom));
   endtask

   task automatic draw_line(int xs, int ys, int xe, int ye,
                            logic [blr_pkg::COLOR_BITS-1:0] color, int steps);
      send_item(blr_pkg::MODE_START, xs, ys, xe, ye, color);
      repeat (steps) send_step();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_image_size(int w, int h);
      csr_write_en   <= 1'b1;
      csr_index      <= blr_pkg::CSR_IMAGE_WIDTH;
      csr_write_data <= w[blr_pkg::CFG_BITS-1:0];
      @(posedge clock);
      csr_index      <= blr_pkg::CSR_IMAGE_HEIGHT;
      csr_write_data <= h[blr_pkg::CFG_BITS-1:0];
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
      cur_width  = w;
      cur_height = h;
   endtask

   task automatic random_lines(int n_items);
      int phase_end;
      int xs;
      int ys;
      int xe;
      int ye;
      int d;
      int major;
      int steps;
      int shape;
      bit held;
      phase_end = sent_count + n_items;
      held = 1'b0;
      while (sent_count < phase_end) begin
         if (!held && sent_count >= phase_end - n_items / 2) begin
            hold_request = 1'b1;
            held = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048, 24'($urandom));
         end else begin
            xs = pick_coord(cur_width);
            ys = pick_coord(cur_height);
            shape = $urandom_range(0, 9);
            case (shape)
               0: begin
                  xe = int'($urandom_range(0, 4095)) - 2048;
                  ye = int'($urandom_range(0, 4095)) - 2048;
               end
               1: begin
                  xe = xs;
                  ye = ys;
               end
               2: begin
                  xe = xs;
                  ye = clamp_coord(ys + int'($urandom_range(0, 24)) - 12);
               end
               3: begin
                  d  = int'($urandom_range(0, 24)) - 12;
                  xe = clamp_coord(xs + d);
                  ye = clamp_coord(($urandom_range(0, 1) == 1) ? ys + d : ys - d);
               end
               default: begin
                  xe = clamp_coord(xs + int'($urandom_range(0, 24)) - 12);
                  ye = clamp_coord(ys + int'($urandom_range(0, 24)) - 12);
               end
            endcase
            major = (xe > xs) ? xe - xs : xs - xe;
            d = (ye > ys) ? ye - ys : ys - ye;
            if (d > major) major = d;
            if (shape == 0) begin
               steps = $urandom_range(0, 30);
            end else if ($urandom_range(0, 5) == 0) begin
               // cut short, next start replaces the line
               steps = $urandom_range(0, major);
            end else begin
               steps = major + $urandom_range(0, 2);
            end
            draw_line(xs, ys, xe, ye, 24'($urandom), steps);
         end
      end
   endtask

   initial begin
      int w;
      int h;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_step();
      draw_line(0, 0, 0, 0, 24'hFFFFFF, 1);
      draw_line(0, 0, 3, 1, 24'h000000, 3);
      draw_line(1, 3, 0, 0, 24'h123456, 3);
      draw_line(0, 0, 1, -3, 24'hABCDEF, 3);
      draw_line(0, 0, 3, -1, 24'h00FF00, 3);
      draw_line(-2048, -2048, 2047, 2047, 24'hFFFFFF, 2);
      draw_line(2047, -2048, -2048, 2047, 24'h800001, 1);

      random_lines(PHASE_ITEMS);
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               w = 1;
               h = 1;
            end
            1: begin
               w = 2048;
               h = 2048;
            end
            2: begin
               w = 0;
               h = 4095;
            end
            3: begin
               w = 4095;
               h = 0;
            end
            4: begin
               w = 4095;
               h = 4095;
            end
            default: begin
               w = $urandom_range(1, 2048);
               h = $urandom_range(1, 2048);
            end
         endcase
         wait_drained();
         set_image_size(w, h);
         random_lines(PHASE_ITEMS);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report_mismatch("results never seen", 64'(sb.pending()), 64'd0);
      end
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/blr_pkg.sv
src/bresenham_line_raster.sv
tb/tb_bresenham_line_raster.sv
